// File: sv/cmma_pkg.sv
// Shared types and constants for the clamp, map and moving-average filter.
// No dependencies; every other file of the block but cmma_ram uses this package.
`timescale 1ns / 1ps

package cmma_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int HLEN_W    = 8;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam cfg_idx_t REG_HISTORY_LEN = 3'd0;
  localparam cfg_idx_t REG_GATE_ENABLE = 3'd1;
  localparam cfg_idx_t REG_MAP_ENABLE  = 3'd2;
  localparam cfg_idx_t REG_GATE_MIN    = 3'd3;
  localparam cfg_idx_t REG_GATE_MAX    = 3'd4;
  localparam cfg_idx_t REG_MAP_MIN     = 3'd5;
  localparam cfg_idx_t REG_MAP_MAX     = 3'd6;

  localparam logic [HLEN_W-1:0] HISTORY_LEN_RST = 8'd1;
  localparam logic              GATE_ENABLE_RST = 1'b1;
  localparam logic              MAP_ENABLE_RST  = 1'b0;
  localparam word_t             GATE_MIN_RST    = 32'sd0;
  localparam word_t             GATE_MAX_RST    = 32'sd65536;
  localparam word_t             MAP_MIN_RST     = 32'sd0;
  localparam word_t             MAP_MAX_RST     = 32'sd65536;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic  busy;
    word_t lo;
    word_t hi;
  } raw_sts_t;

endpackage

// File: sv/cmma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Self-contained; width and depth set by parameters.
`timescale 1ns / 1ps

module cmma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/cmma_mul.sv
// Bit-serial unsigned 32 x 32 shift-add multiplier, one multiplier bit per cycle.
// Depends on cmma_pkg for widths and the request and response structs.
`timescale 1ns / 1ps

module cmma_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  cmma_pkg::mul_req_t req,
  output cmma_pkg::mul_rsp_t rsp
);

  import cmma_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic [PROD_W-1:0] p_r;
  logic [PROD_W-1:0] p_nxt;
  logic [DATA_W-1:0] a_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W:0]   psum;

  assign psum  = {1'b0, p_r[PROD_W-1:DATA_W]} + (p_r[0] ? {1'b0, a_r} : '0);
  assign p_nxt = {psum, p_r[DATA_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      p_r <= {{DATA_W{1'b0}}, req.b};
      a_r <= req.a;
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = p_r;

endmodule

// File: sv/cmma_div.sv
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
// Requires dividend[63:32] < divisor; depends on cmma_pkg for structs and widths.
`timescale 1ns / 1ps

module cmma_div (
  input  logic               clk,
  input  logic               rst_n,
  input  cmma_pkg::div_req_t req,
  output cmma_pkg::div_rsp_t rsp
);

  import cmma_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] lo_r;
  logic [DATA_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              take;

  assign trial = {rem_r, lo_r[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[PROD_W-1:DATA_W];
      lo_r  <= req.dividend[DATA_W-1:0];
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      lo_r  <= {lo_r[DATA_W-2:0], take};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = lo_r;

endmodule

// File: sv/cmma_rawwin.sv
// Raw sample window as a rotating shift line; min and max found one tap per cycle.
// Depends on cmma_pkg for the word type and the status struct.
`timescale 1ns / 1ps

module cmma_rawwin #(
  parameter int DEPTH = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cmma_pkg::word_t    sample,
  output cmma_pkg::raw_sts_t sts
);

  import cmma_pkg::*;

  localparam int CNT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  word_t            win_r [DEPTH];
  word_t            head;
  word_t            lo_r;
  word_t            hi_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  assign head = win_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        win_r[i] <= '0;
      end
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (push) begin
      win_r[0] <= sample;
      for (int i = 1; i < DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      win_r[0] <= win_r[DEPTH-1];
      for (int i = 1; i < DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (cnt_r == '0) begin
        lo_r <= head;
        hi_r <= head;
      end else begin
        if (head < lo_r) begin
          lo_r <= head;
        end
        if (head > hi_r) begin
          hi_r <= head;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.lo   = lo_r;
  assign sts.hi   = hi_r;

endmodule

// File: sv/clamp_map_moving_average.sv
// Clamp, remap and moving-average filter for signed Q16.16 samples, one item in flight.
// A result waits on the serial divider, run once for the mean; with gating and remapping on
// and a positive gate range, the serial multiplier and a second divider run come first.
// The next beat is taken once the result is loaded.
// Reset (synchronous, rst_n low): registers to defaults, raw window zeroed, average restarted.
`timescale 1ns / 1ps

module clamp_map_moving_average #(
  parameter int MAX_WINDOW = 128,
  parameter int RAW_WINDOW = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cmma_pkg::word_t               in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cmma_pkg::word_t               out_mean_out,
  output cmma_pkg::word_t               out_raw_min,
  output cmma_pkg::word_t               out_raw_max,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  cmma_pkg::cfg_idx_t            cfg_index,
  input  logic [cmma_pkg::DATA_W-1:0]   cfg_data
);

  import cmma_pkg::*;

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = DATA_W + CNT_W;
  localparam int IDX_W = CNT_W + 1;
  localparam int LEN_W = (CNT_W > HLEN_W) ? CNT_W : HLEN_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GATE  = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_MDIV  = 4'd4;
  localparam logic [3:0] S_AVG   = 4'd5;
  localparam logic [3:0] S_SUB   = 4'd6;
  localparam logic [3:0] S_ADD   = 4'd7;
  localparam logic [3:0] S_MEAN  = 4'd8;
  localparam logic [3:0] S_MWAIT = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [HLEN_W-1:0]       hl_r;
  logic                    gate_en_r;
  logic                    map_en_r;
  word_t                   gmin_r;
  word_t                   gmax_r;
  word_t                   mmin_r;
  word_t                   mmax_r;

  logic [3:0]              state_r;
  logic [3:0]              state_nxt;
  logic                    out_valid_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        count_r;
  logic [PTR_W-1:0]        wp_r;

  word_t                   x_r;
  logic                    neg_r;
  logic                    full_r;
  word_t                   mean_r;
  word_t                   out_mean_r;
  word_t                   out_min_r;
  word_t                   out_max_r;

  logic                    accept;
  logic                    load_out;
  logic                    restart;
  word_t                   gated;
  logic [DATA_W:0]         in_rng;
  logic [DATA_W:0]         off;
  logic [DATA_W:0]         out_rng;
  logic [DATA_W:0]         out_mag;
  logic                    in_rng_pos;
  word_t                   quo_w;
  word_t                   mapped;
  word_t                   mean_val;
  logic [SUM_W-1:0]        sum_mag;
  logic [LEN_W-1:0]        hl_ext;
  logic [CNT_W-1:0]        eff_len;
  logic [IDX_W-1:0]        wp_ext;
  logic [IDX_W-1:0]        len_ext;
  logic [IDX_W-1:0]        idx_w;
  logic [PTR_W-1:0]        old_idx;
  logic [PTR_W-1:0]        wp_inc;
  logic                    wp_wrap;
  logic [DATA_W-1:0]       ram_rdata;

  mul_req_t                mul_req;
  mul_rsp_t                mul_rsp;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  raw_sts_t                raw_sts;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && (cfg_index == REG_HISTORY_LEN);
  assign load_out  = (state_r == S_DONE) && !raw_sts.busy && (!out_valid_r || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r      <= HISTORY_LEN_RST;
      gate_en_r <= GATE_ENABLE_RST;
      map_en_r  <= MAP_ENABLE_RST;
      gmin_r    <= GATE_MIN_RST;
      gmax_r    <= GATE_MAX_RST;
      mmin_r    <= MAP_MIN_RST;
      mmax_r    <= MAP_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HISTORY_LEN: hl_r      <= cfg_data[HLEN_W-1:0];
        REG_GATE_ENABLE: gate_en_r <= cfg_data[0];
        REG_MAP_ENABLE:  map_en_r  <= cfg_data[0];
        REG_GATE_MIN:    gmin_r    <= cfg_data;
        REG_GATE_MAX:    gmax_r    <= cfg_data;
        REG_MAP_MIN:     mmin_r    <= cfg_data;
        REG_MAP_MAX:     mmax_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // clamp: upper bound first, lower bound last
  always_comb begin
    gated = x_r;
    if (gated > gmax_r) begin
      gated = gmax_r;
    end
    if (gated < gmin_r) begin
      gated = gmin_r;
    end
  end

  assign in_rng     = {gmax_r[DATA_W-1], gmax_r} - {gmin_r[DATA_W-1], gmin_r};
  assign off        = {x_r[DATA_W-1], x_r} - {gmin_r[DATA_W-1], gmin_r};
  assign out_rng    = {mmax_r[DATA_W-1], mmax_r} - {mmin_r[DATA_W-1], mmin_r};
  assign out_mag    = out_rng[DATA_W] ? (~out_rng + 1'b1) : out_rng;
  assign in_rng_pos = !in_rng[DATA_W] && (in_rng != '0);

  assign quo_w    = div_rsp.quo;
  assign mapped   = neg_r ? (mmin_r - quo_w) : (mmin_r + quo_w);
  assign mean_val = neg_r ? -quo_w : quo_w;
  assign sum_mag  = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  // effective history length and oldest entry of the average window
  assign hl_ext = LEN_W'(hl_r);

  always_comb begin
    if (hl_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (hl_ext > LEN_W'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(hl_ext);
    end
  end

  assign wp_ext  = IDX_W'(wp_r);
  assign len_ext = IDX_W'(eff_len);
  assign idx_w   = (wp_ext >= len_ext) ? (wp_ext - len_ext)
                                       : (wp_ext + IDX_W'(MAX_WINDOW) - len_ext);
  assign old_idx = idx_w[PTR_W-1:0];
  assign wp_wrap = (wp_ext + IDX_W'(1)) == IDX_W'(MAX_WINDOW);
  assign wp_inc  = wp_wrap ? '0 : wp_r + 1'b1;

  always_comb begin
    mul_req       = '0;
    mul_req.start = (state_r == S_PREP) && in_rng_pos;
    mul_req.a     = off[DATA_W-1:0];
    mul_req.b     = out_mag[DATA_W-1:0];
  end

  always_comb begin
    div_req = '0;
    if ((state_r == S_MUL) && mul_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = mul_rsp.prod;
      div_req.divisor  = in_rng[DATA_W-1:0];
    end else if (state_r == S_MEAN) begin
      div_req.start    = 1'b1;
      div_req.dividend = PROD_W'(sum_mag);
      div_req.divisor  = DATA_W'(count_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_GATE;
      S_GATE:  state_nxt = (gate_en_r && map_en_r) ? S_PREP : S_AVG;
      S_PREP:  state_nxt = in_rng_pos ? S_MUL : S_AVG;
      S_MUL:   if (mul_rsp.done) state_nxt = S_MDIV;
      S_MDIV:  if (div_rsp.done) state_nxt = S_AVG;
      S_AVG:   state_nxt = S_SUB;
      S_SUB:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_MEAN;
      S_MEAN:  state_nxt = S_MWAIT;
      S_MWAIT: if (div_rsp.done) state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      wp_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (restart) begin
        sum_r   <= '0;
        count_r <= '0;
        wp_r    <= '0;
      end else if ((state_r == S_SUB) && full_r) begin
        sum_r <= sum_r - SUM_W'(word_t'(ram_rdata));
      end else if (state_r == S_ADD) begin
        sum_r   <= sum_r + SUM_W'(x_r);
        count_r <= full_r ? count_r : count_r + 1'b1;
        wp_r    <= wp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_sample;
    end else if ((state_r == S_GATE) && gate_en_r) begin
      x_r <= gated;
    end else if ((state_r == S_PREP) && !in_rng_pos) begin
      x_r <= mmin_r;
    end else if ((state_r == S_MDIV) && div_rsp.done) begin
      x_r <= mapped;
    end
    if (state_r == S_PREP) begin
      neg_r <= out_rng[DATA_W];
    end else if (state_r == S_MEAN) begin
      neg_r <= sum_r[SUM_W-1];
    end
    if (state_r == S_AVG) begin
      full_r <= count_r >= eff_len;
    end
    if ((state_r == S_MWAIT) && div_rsp.done) begin
      mean_r <= mean_val;
    end
    if (load_out) begin
      out_mean_r <= mean_r;
      out_min_r  <= raw_sts.lo;
      out_max_r  <= raw_sts.hi;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_mean_out = out_mean_r;
  assign out_raw_min  = out_min_r;
  assign out_raw_max  = out_max_r;

  cmma_rawwin #(
    .DEPTH (RAW_WINDOW)
  ) u_rawwin (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (accept),
    .sample (in_sample),
    .sts    (raw_sts)
  );

  cmma_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  cmma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  cmma_ram #(
    .WIDTH  (DATA_W),
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (PTR_W)
  ) u_avg_ram (
    .clk   (clk),
    .we    (state_r == S_SUB),
    .waddr (wp_r),
    .wdata (x_r),
    .re    (state_r == S_AVG),
    .raddr (old_idx),
    .rdata (ram_rdata)
  );

endmodule

// File: sv/cmma_checker.sv
// Port-level checks for clamp_map_moving_average, attached by the bind below.
// Depends on cmma_pkg for the word type.
`timescale 1ns / 1ps

module cmma_sva_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input cmma_pkg::word_t out_mean_out,
  input cmma_pkg::word_t out_raw_min,
  input cmma_pkg::word_t out_raw_max
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mean_out)
      && $stable(out_raw_min) && $stable(out_raw_max))
    else $error("stalled result beat changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a beat is in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared the cycle after an input beat");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind clamp_map_moving_average cmma_sva_checker u_cmma_checker (.*);

// File: tb/sv/cmma_checker.sv
// Checker for the clamp, map and moving-average filter: watches the sample, result
// and register channels, predicts every result and compares it field by field.
// Depends on cmma_pkg for the word and register index types.
`timescale 1ns / 1ps

module cmma_checker #(
  parameter int MAX_WINDOW = 128,
  parameter int RAW_WINDOW = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  cmma_pkg::word_t    in_sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  cmma_pkg::word_t    out_mean_out,
  input  cmma_pkg::word_t    out_raw_min,
  input  cmma_pkg::word_t    out_raw_max,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  cmma_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  import cmma_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    word_t mean;
    word_t lo;
    word_t hi;
  } filt_res_t;

  localparam int PRINT_CAP = 60;
  localparam int EXP_DEPTH = 8;

  logic [7:0] hist_len_r;
  logic       gate_en_r;
  logic       map_en_r;
  word_t      gate_lo_r;
  word_t      gate_hi_r;
  word_t      map_lo_r;
  word_t      map_hi_r;

  word_t      avg_win [MAX_WINDOW];
  longint     avg_acc;
  int         avg_n;
  int         avg_wr;
  word_t      raw_win [RAW_WINDOW];
  int         raw_wr;

  filt_res_t  exp_fifo [EXP_DEPTH];
  int         exp_rd   = 0;
  int         exp_wr   = 0;
  int         exp_used = 0;
  int         err_cnt  = 0;
  int         pend_cnt = 0;
  int         beat_no  = 0;

  assign fail_count = err_cnt;
  assign pending    = pend_cnt;

  task automatic flag_mismatch(input string msg);
    if (err_cnt < PRINT_CAP) $display("ERROR %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic word_t remap_gated(input word_t x);
    longint in_rng, off, out_rng, r;
    u64_t   m_in, m_off, m_out, q;
    bit     neg;
    in_rng  = longint'(gate_hi_r) - longint'(gate_lo_r);
    off     = longint'(x) - longint'(gate_lo_r);
    out_rng = longint'(map_hi_r) - longint'(map_lo_r);
    if (in_rng == 0) return map_lo_r;
    neg   = ((off < 0) != (out_rng < 0)) != (in_rng < 0);
    m_in  = u64_t'(in_rng < 0 ? -in_rng : in_rng);
    m_off = u64_t'(off < 0 ? -off : off);
    m_out = u64_t'(out_rng < 0 ? -out_rng : out_rng);
    q = (m_off * m_out) / m_in;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    r = neg ? -longint'(q) : longint'(q);
    r = r + longint'(map_lo_r);
    if (r > longint'(32'sh7FFF_FFFF)) r = longint'(32'sh7FFF_FFFF);
    if (r < longint'(32'sh8000_0000)) r = longint'(32'sh8000_0000);
    return word_t'(r);
  endfunction

  task automatic restart_average();
    avg_acc = 0;
    avg_n   = 0;
    avg_wr  = 0;
  endtask

  task automatic reset_model();
    hist_len_r = HISTORY_LEN_RST;
    gate_en_r  = GATE_ENABLE_RST;
    map_en_r   = MAP_ENABLE_RST;
    gate_lo_r  = GATE_MIN_RST;
    gate_hi_r  = GATE_MAX_RST;
    map_lo_r   = MAP_MIN_RST;
    map_hi_r   = MAP_MAX_RST;
    foreach (avg_win[i]) avg_win[i] = '0;
    foreach (raw_win[i]) raw_win[i] = '0;
    raw_wr = 0;
    restart_average();
  endtask

  task automatic write_model_reg(input cfg_idx_t idx, input logic [31:0] data);
    case (idx)
      REG_HISTORY_LEN: begin
        hist_len_r = data[7:0];
        restart_average();
      end
      REG_GATE_ENABLE: gate_en_r = data[0];
      REG_MAP_ENABLE:  map_en_r  = data[0];
      REG_GATE_MIN:    gate_lo_r = word_t'(data);
      REG_GATE_MAX:    gate_hi_r = word_t'(data);
      REG_MAP_MIN:     map_lo_r  = word_t'(data);
      REG_MAP_MAX:     map_hi_r  = word_t'(data);
      default: ;
    endcase
  endtask

  task automatic compute_filter_output(input word_t s, output filt_res_t res);
    word_t x;
    int    len;
    int    old;
    raw_win[raw_wr] = s;
    raw_wr = (raw_wr + 1 >= RAW_WINDOW) ? 0 : raw_wr + 1;
    res.lo = raw_win[0];
    res.hi = raw_win[0];
    for (int i = 1; i < RAW_WINDOW; i++) begin
      if (raw_win[i] < res.lo) res.lo = raw_win[i];
      if (raw_win[i] > res.hi) res.hi = raw_win[i];
    end

    x = s;
    if (gate_en_r) begin
      if (x > gate_hi_r) x = gate_hi_r;
      if (x < gate_lo_r) x = gate_lo_r;
      if (map_en_r) x = remap_gated(x);
    end

    if (hist_len_r == 0) len = 1;
    else if (int'(hist_len_r) > MAX_WINDOW) len = MAX_WINDOW;
    else len = int'(hist_len_r);
    if (avg_wr >= MAX_WINDOW) avg_wr = 0;
    if (avg_n >= len) begin
      old = (avg_wr + MAX_WINDOW - len) % MAX_WINDOW;
      avg_acc = avg_acc - longint'(avg_win[old]);
      avg_n = len - 1;
    end
    avg_win[avg_wr] = x;
    avg_acc = avg_acc + longint'(x);
    avg_n++;
    avg_wr = (avg_wr + 1 >= MAX_WINDOW) ? 0 : avg_wr + 1;
    res.mean = word_t'(avg_acc / longint'(avg_n));
  endtask

  always @(posedge clk) begin : watch
    filt_res_t want;
    if (!rst_n) begin
      reset_model();
      exp_rd   = 0;
      exp_wr   = 0;
      exp_used = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_used == 0) begin
          flag_mismatch($sformatf("result beat %0d with none expected (mean %0d)",
                                  beat_no, out_mean_out));
        end else begin
          want     = exp_fifo[exp_rd];
          exp_rd   = (exp_rd + 1) % EXP_DEPTH;
          exp_used = exp_used - 1;
          if (out_mean_out !== want.mean)
            flag_mismatch($sformatf("beat %0d mean_out got %0d expected %0d",
                                    beat_no, out_mean_out, want.mean));
          if (out_raw_min !== want.lo)
            flag_mismatch($sformatf("beat %0d raw_min got %0d expected %0d",
                                    beat_no, out_raw_min, want.lo));
          if (out_raw_max !== want.hi)
            flag_mismatch($sformatf("beat %0d raw_max got %0d expected %0d",
                                    beat_no, out_raw_max, want.hi));
        end
        beat_no++;
      end
      if (cfg_valid && cfg_ready) write_model_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        compute_filter_output(in_sample, want);
        if (exp_used >= EXP_DEPTH) begin
          flag_mismatch($sformatf("more than %0d results outstanding", EXP_DEPTH));
        end else begin
          exp_fifo[exp_wr] = want;
          exp_wr   = (exp_wr + 1) % EXP_DEPTH;
          exp_used = exp_used + 1;
        end
      end
    end
    pend_cnt <= exp_used;
  end

endmodule

// File: tb/sv/tb_top.sv
// Top of the filter testbench: clock, reset, sample and register stimulus, result stall
// pattern and the verdict. Depends on cmma_pkg, clamp_map_moving_average and cmma_checker.
`timescale 1ns / 1ps

module tb_top;

  import cmma_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [31:0] hlen;
    logic [31:0] gate_en;
    logic [31:0] map_en;
    word_t       gmin;
    word_t       gmax;
    word_t       mmin;
    word_t       mmax;
  } filt_cfg_t;

  localparam int       MAX_WINDOW  = 128;
  localparam int       RAW_WINDOW  = 20;
  localparam int       ITEM_TARGET = 1420;
  localparam int       LONG_HOLD   = 600;
  localparam int       TAIL_CYCLES = 250;
  localparam int       CYCLE_LIMIT = 2500000;
  localparam int       HOLD_PHASE  = 5;
  localparam cfg_idx_t REG_SPARE   = 3'd7;
  localparam word_t    W_MAX       = 32'sh7FFF_FFFF;
  localparam word_t    W_MIN       = 32'sh8000_0000;
  localparam word_t    ONE_Q       = 32'sd65536;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  word_t       in_sample    = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  word_t       out_mean_out;
  word_t       out_raw_min;
  word_t       out_raw_max;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index    = '0;
  logic [31:0] cfg_data     = '0;

  int          fail_count;
  int          pending;
  int          cycle_cnt    = 0;
  int          hold_id      = 0;
  int          items_sent   = 0;
  int          burst_left   = 0;
  bit          gapless      = 1'b0;
  bit          in_live      = 1'b0;
  filt_cfg_t   cur_cfg;

  clamp_map_moving_average #(
    .MAX_WINDOW (MAX_WINDOW),
    .RAW_WINDOW (RAW_WINDOW)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_mean_out (out_mean_out),
    .out_raw_min  (out_raw_min),
    .out_raw_max  (out_raw_max),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  cmma_checker #(
    .MAX_WINDOW (MAX_WINDOW),
    .RAW_WINDOW (RAW_WINDOW)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_mean_out (out_mean_out),
    .out_raw_min  (out_raw_min),
    .out_raw_max  (out_raw_max),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stall segments, plus a long hold on request
  initial begin : rx_stall
    int hold_seen;
    int hold_left;
    int seg_left;
    int pct;
    hold_seen = 0;
    hold_left = 0;
    seg_left  = 0;
    pct       = 0;
    forever begin
      @(posedge clk);
      if (hold_id != hold_seen) begin
        hold_seen = hold_id;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(40, 1);
          case ($urandom_range(4))
            0, 1: pct = 0;
            2: pct = 25;
            3: pct = 55;
            default: pct = 90;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(99) < pct);
      end
    end
  end

  task automatic send_sample(input word_t s);
    int gap;
    in_valid  <= 1'b1;
    in_sample <= s;
    in_live    = 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (!gapless) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(25, 1);
        gap = ($urandom_range(3) == 0) ? $urandom_range(120, 20) : $urandom_range(8, 1);
        in_valid <= 1'b0;
        in_live   = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_list(input word_t vals[$]);
    foreach (vals[i]) send_sample(vals[i]);
  endtask

  task automatic wait_results_drained();
    if (in_live) begin
      in_valid <= 1'b0;
      in_live   = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // mask bit i writes register i; bit 7 pokes the unused index
  task automatic load_filter_cfg(input filt_cfg_t c, input logic [7:0] mask);
    if (mask[REG_HISTORY_LEN]) begin
      write_reg(REG_HISTORY_LEN, c.hlen);
      cur_cfg.hlen = c.hlen;
    end
    if (mask[REG_GATE_ENABLE]) begin
      write_reg(REG_GATE_ENABLE, c.gate_en);
      cur_cfg.gate_en = c.gate_en;
    end
    if (mask[REG_MAP_ENABLE]) begin
      write_reg(REG_MAP_ENABLE, c.map_en);
      cur_cfg.map_en = c.map_en;
    end
    if (mask[REG_GATE_MIN]) begin
      write_reg(REG_GATE_MIN, c.gmin);
      cur_cfg.gmin = c.gmin;
    end
    if (mask[REG_GATE_MAX]) begin
      write_reg(REG_GATE_MAX, c.gmax);
      cur_cfg.gmax = c.gmax;
    end
    if (mask[REG_MAP_MIN]) begin
      write_reg(REG_MAP_MIN, c.mmin);
      cur_cfg.mmin = c.mmin;
    end
    if (mask[REG_MAP_MAX]) begin
      write_reg(REG_MAP_MAX, c.mmax);
      cur_cfg.mmax = c.mmax;
    end
    if (mask[7]) write_reg(REG_SPARE, $urandom());
    if (mask != 8'h00) cfg_valid <= 1'b0;
  endtask

  function automatic filt_cfg_t rand_filter_cfg();
    filt_cfg_t c;
    word_t     a, b, ctr;
    int        hl;
    case ($urandom_range(6))
      0: hl = 0;
      1: hl = 1;
      2: hl = 128;
      3: hl = $urandom_range(255, 129);
      4: hl = $urandom_range(8, 2);
      default: hl = $urandom_range(128, 1);
    endcase
    c.hlen    = ($urandom() & 32'hFFFF_FF00) | hl;
    c.gate_en = ($urandom() & ~32'h1) | ($urandom_range(3) != 0);
    c.map_en  = ($urandom() & ~32'h1) | ($urandom_range(4) > 1);

    a = $urandom();
    b = $urandom();
    case ($urandom_range(6))
      0: begin
        c.gmin = (a < b) ? a : b;
        c.gmax = (a < b) ? b : a;
      end
      1, 2: begin
        ctr = word_t'($urandom_range(32'h7FFFF)) - 32'sh40000;
        hl  = $urandom_range(32'h20000, 1);
        c.gmin = ctr - hl;
        c.gmax = ctr + hl;
      end
      3: begin
        c.gmin = (a < b) ? b : a;
        c.gmax = (a < b) ? a : b;
      end
      4: begin
        c.gmin = a;
        c.gmax = a;
      end
      5: begin
        c.gmin = W_MIN;
        c.gmax = W_MAX;
      end
      default: begin
        c.gmin = W_MIN;
        c.gmax = a;
      end
    endcase

    a = $urandom();
    b = $urandom();
    case ($urandom_range(5))
      0, 1: begin
        c.mmin = a;
        c.mmax = b;
      end
      2: begin
        c.mmin = W_MIN;
        c.mmax = W_MAX;
      end
      3: begin
        c.mmin = W_MAX;
        c.mmax = W_MIN;
      end
      4: begin
        c.mmin = a;
        c.mmax = a;
      end
      default: begin
        c.mmin = word_t'($urandom_range(32'hFFFFF)) - 32'sh80000;
        c.mmax = c.mmin + word_t'($urandom_range(32'h3FFFFF));
      end
    endcase
    return c;
  endfunction

  function automatic word_t pick_sample(input filt_cfg_t c);
    word_t  s;
    longint span;
    u64_t   r64;
    case ($urandom_range(9))
      0, 1, 2: s = $urandom();
      3, 4, 5: begin
        span = longint'(c.gmax) - longint'(c.gmin);
        if (span <= 0) begin
          s = c.gmin;
        end else begin
          r64 = {$urandom(), $urandom()};
          s = word_t'(longint'(c.gmin) + longint'(r64 % u64_t'(span + 1)));
        end
      end
      6: begin
        case ($urandom_range(3))
          0: s = c.gmin - 1;
          1: s = c.gmin;
          2: s = c.gmax;
          default: s = c.gmax + 1;
        endcase
      end
      7: begin
        case ($urandom_range(3))
          0: s = W_MIN;
          1: s = W_MAX;
          2: s = '0;
          default: s = -1;
        endcase
      end
      default: s = word_t'($urandom_range(32'h3FFFF)) - 32'sh20000;
    endcase
    return s;
  endfunction

  initial begin : stimulus
    filt_cfg_t   c;
    word_t       vec[$];
    logic [7:0]  mask;
    int          phase_no;
    int          n;

    cur_cfg = '{32'd1, 32'd1, 32'd0, GATE_MIN_RST, GATE_MAX_RST, MAP_MIN_RST, MAP_MAX_RST};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: gate to [0, 1.0], no remap, single-sample history
    vec = '{32'sd0, W_MAX, W_MIN, 32'sd32768, -32'sd1};
    send_list(vec);

    // gate off, sum of three full-scale samples overflows 32 bits
    wait_results_drained();
    c = cur_cfg;
    c.hlen    = 32'h5A5A_5A03;
    c.gate_en = 32'hFFFF_FFFE;
    load_filter_cfg(c, 8'h03);
    vec = '{W_MAX, W_MAX, W_MAX, W_MIN};
    send_list(vec);

    // zero history acts as one; remap onto the full range saturates
    wait_results_drained();
    c = '{32'hABCD_EF00, 32'h1, 32'h1, -ONE_Q, ONE_Q, W_MIN, W_MAX};
    load_filter_cfg(c, 8'hFF);
    vec = '{W_MIN, W_MAX, 32'sd0, 32'sd1};
    send_list(vec);

    // crossed gate bounds: lower bound wins
    wait_results_drained();
    c = cur_cfg;
    c.hlen = 32'd128;
    c.gmin = 32'sd100 * ONE_Q;
    c.gmax = -32'sd100 * ONE_Q;
    load_filter_cfg(c, 8'h19);
    vec = '{32'sd0, W_MAX};
    send_list(vec);

    // zero gate range maps to map_min; history above the window size clamps
    wait_results_drained();
    c = '{32'd255, 32'h1, 32'h1, 32'sd5 * ONE_Q, 32'sd5 * ONE_Q,
          -32'sd3 * ONE_Q, 32'sd7 * ONE_Q};
    load_filter_cfg(c, 8'h79);
    vec = '{W_MIN, 32'sd5 * ONE_Q};
    send_list(vec);

    // full gate range, reversed map range
    wait_results_drained();
    c = '{32'd2, 32'h1, 32'h1, W_MIN, W_MAX, W_MAX, W_MIN};
    load_filter_cfg(c, 8'h79);
    vec = '{W_MIN, W_MAX, 32'sd0, 32'sd12345};
    send_list(vec);

    // map enabled but gating off: sample passes untouched
    wait_results_drained();
    c = cur_cfg;
    c.hlen    = 32'd128;
    c.gate_en = 32'h0;
    load_filter_cfg(c, 8'h03);
    vec = '{32'sh4000_0000, -32'sh4000_0000, 32'sd7};
    send_list(vec);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_results_drained();
      c = rand_filter_cfg();
      if (phase_no % 4 == 0) mask = 8'h7F;
      else mask = $urandom_range(255, 1);
      load_filter_cfg(c, mask);
      n = $urandom_range(100, 15);
      if (phase_no == HOLD_PHASE) begin
        // back-pressure: receiver holds off while samples keep coming
        hold_id <= hold_id + 1;
        gapless  = 1'b1;
        n = 30;
      end
      repeat (n) send_sample(pick_sample(cur_cfg));
      gapless = 1'b0;
      phase_no++;
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/cmma_pkg.sv
sv/cmma_ram.sv
sv/cmma_mul.sv
sv/cmma_div.sv
sv/cmma_rawwin.sv
sv/clamp_map_moving_average.sv
sv/cmma_checker.sv
tb/sv/cmma_checker.sv
tb/sv/tb_top.sv
